@@ rtl/acfp_pkg.sv @@
// Shared types and constants for the ASCII command frame parser.
// Holds character codes, keyword tables, action codes and the per-beat step control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acfp_pkg;

    // Action codes carried on the result stream
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_RUN    = 3'd1;
    localparam logic [2:0] ACT_CLIMB  = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_LAUNCH = 3'd4;
    localparam logic [2:0] ACT_PACKET = 3'd5;

    // Opcode of an input beat
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_Y_UP  = 8'h59;
    localparam logic [7:0] CH_Y_LO  = 8'h79;

    // Link timeout after reset
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Keyword matchers: two spellings for each of run, climb and stop
    localparam int KW_NUM = 6;
    localparam logic [7:0] KW_CHARS [KW_NUM][6] = '{
        '{8'h40, 8'h52, 8'h55, 8'h4E, 8'h00, 8'h00},  // @RUN
        '{8'h40, 8'h72, 8'h75, 8'h6E, 8'h00, 8'h00},  // @run
        '{8'h40, 8'h43, 8'h4C, 8'h49, 8'h4D, 8'h42},  // @CLIMB
        '{8'h40, 8'h63, 8'h6C, 8'h69, 8'h6D, 8'h62},  // @climb
        '{8'h40, 8'h53, 8'h54, 8'h4F, 8'h50, 8'h00},  // @STOP
        '{8'h40, 8'h73, 8'h74, 8'h6F, 8'h70, 8'h00}   // @stop
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd4, 3'd6, 3'd6, 3'd5, 3'd5};

    // Per-beat control handed to the matchers and the number parser
    typedef struct packed {
        logic       step;   // a text character is consumed this cycle
        logic       clear;  // the frame ends this cycle
        logic [7:0] ch;
    } t_step_ctl;

endpackage

`default_nettype wire

@@ rtl/acfp_kw_match.sv @@
// Keyword matchers for the command frame parser: @RUN, @CLIMB, @STOP (both cases) and Y/y.
// Depends on acfp_pkg for the keyword tables and the step control struct.
`timescale 1ns / 1ps
`default_nettype none

module acfp_kw_match (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire acfp_pkg::t_step_ctl i_ctl,
    output logic [3:0]              o_found_nx   // run, climb, stop, launch after this beat
);

    logic [2:0] r_prog [acfp_pkg::KW_NUM];
    logic [2:0] n_prog [acfp_pkg::KW_NUM];
    logic [3:0] r_found;
    logic [3:0] n_found;

    // Advance all six matchers in parallel on a consumed character
    always_comb begin
        logic [2:0] p;
        n_found = r_found;
        for (int i = 0; i < acfp_pkg::KW_NUM; i++) begin
            p = r_prog[i];
            if (i_ctl.step) begin
                if (p < acfp_pkg::KW_LEN[i] && i_ctl.ch == acfp_pkg::KW_CHARS[i][p]) begin
                    p = p + 3'd1;
                end else begin
                    p = (i_ctl.ch == acfp_pkg::CH_AT) ? 3'd1 : 3'd0;
                end
                if (p >= acfp_pkg::KW_LEN[i]) begin
                    n_found[i >> 1] = 1'b1;
                    p = 3'd0;
                end
            end
            n_prog[i] = p;
        end
        if (i_ctl.step && (i_ctl.ch == acfp_pkg::CH_Y_UP || i_ctl.ch == acfp_pkg::CH_Y_LO)) begin
            n_found[3] = 1'b1;
        end
    end

    assign o_found_nx = n_found;

    // Matcher state, cleared at every frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= '0;
            for (int i = 0; i < acfp_pkg::KW_NUM; i++) r_prog[i] <= '0;
        end else begin
            r_found <= n_found;
            for (int i = 0; i < acfp_pkg::KW_NUM; i++) r_prog[i] <= n_prog[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/acfp_num_parse.sv @@
// Packet parser for the command frame parser: "<a,b,c,d,e>" with five saturating integers.
// Depends on acfp_pkg for character codes and the step control struct.
`timescale 1ns / 1ps
`default_nettype none

module acfp_num_parse #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire acfp_pkg::t_step_ctl    i_ctl,
    output logic                        o_ok,       // five values parsed as of this beat
    output logic [VALUE_WIDTH-1:0]      o_vals [5]
);

    localparam int AccW = VALUE_WIDTH + 4;
    localparam logic [VALUE_WIDTH-1:0] Cap = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SKIPWS,
        PH_SIGNED,
        PH_DIGITS,
        PH_DONE,
        PH_FAILED
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_fi, n_fi;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_pend [5];
    logic                   w_wr;
    logic [VALUE_WIDTH-1:0] w_wr_val;
    logic                   w_digit;
    logic                   w_space;
    logic [VALUE_WIDTH-1:0] w_dval;
    logic [AccW-1:0]        w_mac;

    // Close a number: negate, or clamp a positive magnitude to the largest value
    function automatic logic [VALUE_WIDTH-1:0] fin(input logic [VALUE_WIDTH-1:0] acc,
                                                  input logic neg);
        logic [VALUE_WIDTH-1:0] v;
        if (neg) v = '0 - acc;
        else     v = (acc >= Cap) ? Cap - 1'b1 : acc;
        return v;
    endfunction

    // Character classes and the decimal multiply-accumulate
    assign w_digit  = (i_ctl.ch >= acfp_pkg::CH_ZERO) && (i_ctl.ch <= acfp_pkg::CH_NINE);
    assign w_space  = (i_ctl.ch == acfp_pkg::CH_SPACE) ||
                      ((i_ctl.ch >= acfp_pkg::CH_TAB) && (i_ctl.ch <= acfp_pkg::CH_CR));
    assign w_dval   = VALUE_WIDTH'(i_ctl.ch[3:0]);
    assign w_mac    = (AccW'(r_acc) << 3) + (AccW'(r_acc) << 1) + AccW'(i_ctl.ch[3:0]);
    assign w_wr_val = fin(r_acc, r_neg);

    // Phase transitions for one consumed character
    always_comb begin
        n_phase = r_phase;
        n_fi    = r_fi;
        n_acc   = r_acc;
        n_neg   = r_neg;
        w_wr    = 1'b0;
        if (i_ctl.step) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (i_ctl.ch == acfp_pkg::CH_LT) begin
                        n_phase = PH_SKIPWS;
                        n_acc   = '0;
                        n_neg   = 1'b0;
                    end
                end
                PH_SKIPWS, PH_SIGNED: begin
                    if (r_phase == PH_SKIPWS && w_space) begin
                        n_phase = PH_SKIPWS;
                    end else if (r_phase == PH_SKIPWS &&
                                 (i_ctl.ch == acfp_pkg::CH_PLUS ||
                                  i_ctl.ch == acfp_pkg::CH_MINUS)) begin
                        n_neg   = (i_ctl.ch == acfp_pkg::CH_MINUS);
                        n_phase = PH_SIGNED;
                    end else if (w_digit) begin
                        n_acc   = w_dval;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_FAILED;
                    end
                end
                PH_DIGITS: begin
                    if (w_digit) begin
                        n_acc = (w_mac > AccW'(Cap)) ? Cap : w_mac[VALUE_WIDTH-1:0];
                    end else begin
                        w_wr = 1'b1;
                        if (r_fi >= 3'd4) begin
                            n_phase = PH_DONE;
                        end else if (i_ctl.ch == acfp_pkg::CH_COMMA) begin
                            n_fi    = r_fi + 3'd1;
                            n_phase = PH_SKIPWS;
                            n_acc   = '0;
                            n_neg   = 1'b0;
                        end else begin
                            n_phase = PH_FAILED;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Commit view: a frame ending inside the fifth number closes it here
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            o_vals[i] = (w_wr && r_fi == 3'(i)) ? w_wr_val : r_pend[i];
        end
        if (n_phase == PH_DIGITS) begin
            o_vals[4] = fin(n_acc, n_neg);
        end
        o_ok = (n_phase == PH_DONE) || (n_phase == PH_DIGITS && n_fi >= 3'd4);
    end

    // Parser state; pending values need no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_pend[r_fi] <= w_wr_val;
        end
        if (!i_rst_n || i_ctl.clear) begin
            r_phase <= PH_SEARCH;
            r_fi    <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_fi    <= n_fi;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ascii_command_frame_parser_top.sv @@
// Top level of the ASCII command frame parser: input register, frame bookkeeping,
// command decision, stored packet values, link timeout and the result register.
// Depends on acfp_pkg, acfp_kw_match and acfp_num_parse.
//
//  channel | dir | beat contents (low bit first)                        | handshake
//  s_      | in  | tdata: data_byte; tuser: opcode; tlast: frame_end     | tvalid/tready
//  m_      | out | tdata: 5 x 16-bit values, online; tuser: action       | tvalid/tready
//  cfg     | in  | i_cfg_wdata: timeout_ticks                            | i_cfg_we
//
// One beat per cycle is taken while the input register is not held (see below); a beat sits in
// the input register, and its result, if any, is loaded from there into the output register.
// The input register drains into the parse logic every cycle unless it holds a beat that
// makes a result while the output register is full and not being taken.
// i_rst_n is synchronous, active low; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module ascii_command_frame_parser_top #(
    parameter int FRAME_BYTES = 128,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [7:0] data_byte
    input  wire logic [0:0]     s_tuser,    // [0] opcode
    input  wire logic           s_tlast,    // frame_end
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [87:0]         m_tdata,    // [15:0] forward_speed, [31:16] side_speed,
                                            // [47:32] left_trigger, [63:48] right_trigger,
                                            // [79:64] button_bits, [80] online, zero above
    output logic [2:0]          m_tuser,    // [2:0] action
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_wdata // timeout_ticks
);

    localparam int CntW = $clog2(FRAME_BYTES);
    localparam int ExtW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;
    localparam logic [CntW-1:0] TextMax = CntW'(FRAME_BYTES - 1);

    // Input register
    logic                   r_in_vld;
    logic                   r_in_op;
    logic [7:0]             r_in_ch;
    logic                   r_in_fe;

    // Frame and link state
    logic [CntW-1:0]        r_cnt;
    logic                   r_ended;
    logic [15:0]            r_timeout;
    logic [15:0]            r_idle, n_idle;
    logic [15:0]            r_store [5];
    logic [15:0]            n_store [5];

    // Result register
    logic                   r_m_vld;
    logic [2:0]             r_m_act;
    logic [15:0]            r_m_val [5];
    logic                   r_m_online;

    logic                   w_produce;
    logic                   w_out_free;
    logic                   w_fire;
    logic                   w_byte;
    logic                   w_in_text;
    logic                   w_end;
    logic                   w_commit;
    logic [2:0]             w_act;
    acfp_pkg::t_step_ctl    w_ctl;
    logic [3:0]             w_found;
    logic                   w_ok;
    logic [VALUE_WIDTH-1:0] w_vals [5];

    // Handshake: a beat leaves the input register unless its result would be blocked
    assign w_produce  = r_in_vld && (r_in_op == acfp_pkg::OP_TICK || r_in_fe);
    assign w_out_free = !r_m_vld || m_tready;
    assign w_fire     = r_in_vld && (!w_produce || w_out_free);
    assign s_tready   = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tready) begin
            r_in_vld <= s_tvalid;
        end
        if (s_tready) begin
            r_in_op <= s_tuser[0];
            r_in_ch <= s_tdata;
            r_in_fe <= s_tlast;
        end
    end

    // Text window of the current frame
    assign w_byte    = w_fire && r_in_op == acfp_pkg::OP_BYTE;
    assign w_in_text = !r_ended && (r_cnt < TextMax);
    assign w_end     = w_byte && r_in_fe;

    assign w_ctl.step  = w_byte && w_in_text && r_in_ch != acfp_pkg::CH_NUL;
    assign w_ctl.clear = w_end;
    assign w_ctl.ch    = r_in_ch;

    acfp_kw_match u_kw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_found_nx (w_found)
    );

    acfp_num_parse #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_ok    (w_ok),
        .o_vals  (w_vals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_cnt   <= '0;
            r_ended <= 1'b0;
        end else if (w_byte && w_in_text) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_in_ch == acfp_pkg::CH_NUL) begin
                r_ended <= 1'b1;
            end
        end
    end

    // Command decision by fixed priority, then the packet
    always_comb begin
        w_commit = 1'b0;
        if (w_found[0])      w_act = acfp_pkg::ACT_RUN;
        else if (w_found[1]) w_act = acfp_pkg::ACT_CLIMB;
        else if (w_found[2]) w_act = acfp_pkg::ACT_STOP;
        else if (w_found[3]) w_act = acfp_pkg::ACT_LAUNCH;
        else if (w_ok) begin
            w_act    = acfp_pkg::ACT_PACKET;
            w_commit = w_end;
        end else begin
            w_act = acfp_pkg::ACT_NONE;
        end
    end

    // Stored values and idle tick count
    always_comb begin
        logic [ExtW-1:0] ext;
        for (int i = 0; i < 5; i++) begin
            ext        = ExtW'(w_vals[i]);
            n_store[i] = w_commit ? ext[15:0] : r_store[i];
        end
        n_idle = r_idle;
        if (w_fire && r_in_op == acfp_pkg::OP_TICK) begin
            if (r_idle != 16'hFFFF) n_idle = r_idle + 16'd1;
        end else if (w_commit) begin
            n_idle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= acfp_pkg::TIMEOUT_RESET;
            r_idle    <= '0;
            for (int i = 0; i < 5; i++) r_store[i] <= '0;
        end else begin
            if (i_cfg_we) r_timeout <= i_cfg_wdata;
            r_idle <= n_idle;
            for (int i = 0; i < 5; i++) r_store[i] <= n_store[i];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_fire && w_produce) begin
            r_m_vld <= 1'b1;
        end else if (m_tready) begin
            r_m_vld <= 1'b0;
        end
        if (w_fire && w_produce) begin
            r_m_act    <= (r_in_op == acfp_pkg::OP_TICK) ? acfp_pkg::ACT_NONE : w_act;
            r_m_online <= (n_idle <= r_timeout);
            for (int i = 0; i < 5; i++) r_m_val[i] <= n_store[i];
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tuser  = r_m_act;
    assign m_tdata  = {7'd0, r_m_online, r_m_val[4], r_m_val[3], r_m_val[2],
                       r_m_val[1], r_m_val[0]};

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ascii_command_frame_parser_top: directed frames, then random
// packet, command, noise and tick traffic under several link timeouts, checked beat by beat.
// Depends on acfp_pkg and the parser RTL; needs no files or arguments.

module tb_top;

    localparam int          FRAME_TEXT  = 127;      // characters of a frame that count
    localparam int unsigned MAG_CAP     = 32768;    // magnitude limit of a 16-bit value
    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [7:0]  FILLER      = 8'h61;    // 'a', neutral padding
    localparam logic [7:0]  CH_GT       = 8'h3E;

    typedef enum logic [2:0] {SEEK_LT, SKIP_WS, AFTER_SIGN, IN_DIGITS, PARSED, BROKEN} t_scan;

    typedef struct {
        logic       op;
        logic [7:0] ch;
        logic       last;
        bit         typed;
        logic [2:0] t_action;
        bit         t_online;
    } t_beat;

    typedef struct packed {
        logic [2:0]       action;
        logic [4:0][15:0] vals;
        logic             online;
    } t_report;

    typedef struct {
        bit         tick;
        bit         tick_last;
        int         pad;
        string      head;
        bit         nul;
        string      tail;
        bit         typed;
        logic [2:0] act;
        bit         onl;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_tuser     = 1'b0;    // [0] opcode
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [87:0] m_tdata;               // [79:0] five stored values, [80] online
    logic [2:0]  m_tuser;               // [2:0] action
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;

    ascii_command_frame_parser_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the parser state.
    int unsigned      text_len;
    bit               text_stop;
    int               kw_pos [6];
    bit               kw_hit [4];
    t_scan            scan;
    int               fidx;
    int unsigned      acc;
    bit               neg;
    logic [4:0][15:0] pend_vals;
    logic [4:0][15:0] kept_vals;
    int unsigned      idle_cnt;
    logic [15:0]      limit_ticks;

    // Traffic and scoreboard bookkeeping.
    t_beat    tx_q [$];
    t_beat    on_bus;
    t_report  due_reports [$];
    logic [7:0] fbuf [$];
    bit       calm = 1'b0;
    int       beats_queued, beats_taken, results_seen, mismatches, cycles;
    int       n_frames, n_packets, n_cmds, n_ticks, n_settings;

    string kw_word [6] = '{"@RUN", "@run", "@CLIMB", "@climb", "@STOP", "@stop"};
    string cmd_words [12] = '{"@RUN", "@run", "@CLIMB", "@climb", "@STOP", "@stop",
                              "Y", "y", "@CLIM", "@sto", "@Ru", "@@run"};
    string val_name [5] = '{"forward_speed", "side_speed", "left_trigger",
                            "right_trigger", "button_bits"};
    string junk_set = "abcdfxz0189 ,.>#:";
    int unsigned bound_mags [8] = '{0, 9, 32766, 32767, 32768, 32769, 65535, 99999};

    // Directed frames; the action and online flag are typed in where they are plain.
    t_dir_row dir_table [23] = '{
        '{1, 0, 0,   "",                               0, "",     1, acfp_pkg::ACT_NONE,   1},
        '{0, 0, 0,   "@RUN",                           0, "",     1, acfp_pkg::ACT_RUN,    1},
        '{0, 0, 0,   "x@run",                          0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "@CLIMB",                         0, "",     1, acfp_pkg::ACT_CLIMB,  1},
        '{0, 0, 0,   "@stop",                          0, "",     1, acfp_pkg::ACT_STOP,   1},
        '{0, 0, 0,   "Y",                              0, "",     1, acfp_pkg::ACT_LAUNCH, 1},
        '{0, 0, 0,   "zzy",                            0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "Y@STOP",                         0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "a@stopy@climb",                  0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "@RU@RUN",                        0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "<32767,-32768,+0,99999,-99999>", 0, "",     1, acfp_pkg::ACT_PACKET, 1},
        '{0, 0, 0,   "< \t1,\015-2,  +3,4,5",          0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "<1,2,3,4>",                      0, "",     1, acfp_pkg::ACT_NONE,   1},
        '{0, 0, 0,   "<1,,3,4,5>",                     0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "ab<1,2<3,4,5,6,7>",              0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "<- 5,1,1,1,1>",                  0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "<7,-8,9,10,-11",                 1, "@RUN", 0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 0,   "\377",                           0, "",     1, acfp_pkg::ACT_NONE,   1},
        '{0, 0, 123, "@RUN",                           0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 126, "@RUN",                           0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{1, 1, 0,   "",                               0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 121, "<1,2,3,4,5",                     0, "",     0, acfp_pkg::ACT_NONE,   0},
        '{0, 0, 117, "<1,2,3,4,5",                     0, "",     0, acfp_pkg::ACT_NONE,   0}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, due_reports.size());
            $display("ascii_command_frame_parser_top verification failed");
            $finish;
        end
    end

    // Clears the per-frame matcher and number scanner.
    function automatic void new_frame();
        text_len  = 0;
        text_stop = 1'b0;
        foreach (kw_pos[i]) kw_pos[i] = 0;
        foreach (kw_hit[i]) kw_hit[i] = 1'b0;
        scan = SEEK_LT;
        fidx = 0;
        acc  = 0;
        neg  = 1'b0;
    endfunction

    function automatic void open_value();
        scan = SKIP_WS;
        acc  = 0;
        neg  = 1'b0;
    endfunction

    // Saturates the magnitude into a 16-bit two's complement value.
    function automatic void close_value();
        if (neg)
            pend_vals[fidx] = 16'(0 - acc);
        else
            pend_vals[fidx] = (acc >= MAG_CAP) ? 16'h7FFF : 16'(acc);
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == acfp_pkg::CH_SPACE || (c >= acfp_pkg::CH_TAB && c <= acfp_pkg::CH_CR);
    endfunction

    function automatic void scan_char(logic [7:0] c);
        bit dig;
        dig = (c >= acfp_pkg::CH_ZERO && c <= acfp_pkg::CH_NINE);
        case (scan)
            SEEK_LT: begin
                if (c == acfp_pkg::CH_LT) open_value();
            end
            SKIP_WS, AFTER_SIGN: begin
                if (scan == SKIP_WS && is_ws(c)) begin
                end else if (scan == SKIP_WS &&
                             (c == acfp_pkg::CH_PLUS || c == acfp_pkg::CH_MINUS)) begin
                    neg  = (c == acfp_pkg::CH_MINUS);
                    scan = AFTER_SIGN;
                end else if (dig) begin
                    acc  = c - acfp_pkg::CH_ZERO;
                    scan = IN_DIGITS;
                end else begin
                    scan = BROKEN;
                end
            end
            IN_DIGITS: begin
                if (dig) begin
                    acc = acc * 10 + (c - acfp_pkg::CH_ZERO);
                    if (acc > MAG_CAP) acc = MAG_CAP;
                end else begin
                    close_value();
                    if (fidx >= 4) begin
                        scan = PARSED;
                    end else if (c == acfp_pkg::CH_COMMA) begin
                        fidx++;
                        open_value();
                    end else begin
                        scan = BROKEN;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Keyword matchers restart on a mismatch, or at one when the mismatch is an '@'.
    function automatic void match_char(logic [7:0] c);
        int p;
        for (int i = 0; i < 6; i++) begin
            p = kw_pos[i];
            if (p < kw_word[i].len() && c == kw_word[i][p])
                p++;
            else
                p = (c == acfp_pkg::CH_AT) ? 1 : 0;
            if (p >= kw_word[i].len()) begin
                kw_hit[i / 2] = 1'b1;
                p = 0;
            end
            kw_pos[i] = p;
        end
        if (c == acfp_pkg::CH_Y_UP || c == acfp_pkg::CH_Y_LO) kw_hit[3] = 1'b1;
    endfunction

    // Applies one accepted beat and queues the report it causes, if any.
    function automatic void step_parser(t_beat b);
        t_report    r;
        logic [2:0] act;
        bit         ok;
        act = acfp_pkg::ACT_NONE;
        ok  = 1'b0;
        beats_taken++;
        if (b.op == acfp_pkg::OP_TICK) begin
            if (idle_cnt < 65535) idle_cnt++;
            n_ticks++;
        end else begin
            if (!text_stop && text_len < FRAME_TEXT) begin
                if (b.ch == acfp_pkg::CH_NUL) begin
                    text_stop = 1'b1;
                end else begin
                    match_char(b.ch);
                    scan_char(b.ch);
                end
                text_len++;
            end
            if (!b.last) return;
            n_frames++;
            if (kw_hit[0]) act = acfp_pkg::ACT_RUN;
            else if (kw_hit[1]) act = acfp_pkg::ACT_CLIMB;
            else if (kw_hit[2]) act = acfp_pkg::ACT_STOP;
            else if (kw_hit[3]) act = acfp_pkg::ACT_LAUNCH;
            else begin
                if (scan == PARSED) begin
                    ok = 1'b1;
                end else if (scan == IN_DIGITS && fidx >= 4) begin
                    close_value();
                    ok = 1'b1;
                end
                if (ok) begin
                    kept_vals = pend_vals;
                    idle_cnt  = 0;
                    act       = acfp_pkg::ACT_PACKET;
                    n_packets++;
                end
            end
            if (act != acfp_pkg::ACT_NONE && act != acfp_pkg::ACT_PACKET) n_cmds++;
            new_frame();
        end
        r.action = b.typed ? b.t_action : act;
        r.vals   = kept_vals;
        r.online = b.typed ? b.t_online : (idle_cnt <= limit_ticks);
        due_reports.push_back(r);
    endfunction

    function automatic void flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch at %0t, result %0d, %s: expected %h, got %h",
                     $time, results_seen, what, want, got);
    endfunction

    // Compares one accepted result beat with the oldest prediction.
    function automatic void check_result();
        t_report e;
        results_seen++;
        if (due_reports.size() == 0) begin
            flag_mismatch("unexpected result, action", 16'd0, 16'(m_tuser));
            return;
        end
        e = due_reports.pop_front();
        if (m_tuser !== e.action) flag_mismatch("action", 16'(e.action), 16'(m_tuser));
        for (int k = 0; k < 5; k++)
            if (m_tdata[16*k +: 16] !== e.vals[k])
                flag_mismatch(val_name[k], e.vals[k], m_tdata[16*k +: 16]);
        if (m_tdata[80] !== e.online) flag_mismatch("online", 16'(e.online), 16'(m_tdata[80]));
    endfunction

    // Sender: keeps a beat steady until taken, then either idles or presents the next one.
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) step_parser(on_bus);
        if (!s_tvalid || s_tready) begin
            if (i_rst_n && tx_q.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
                on_bus = tx_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= on_bus.ch;
                s_tuser  <= on_bus.op;
                s_tlast  <= on_bus.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result beat and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) check_result();
        m_tready <= calm || ($urandom_range(99) >= 31);
    end

    task automatic add_beat(logic op, logic [7:0] ch, logic last, bit typed,
                            logic [2:0] act, bit onl);
        t_beat b;
        b.op       = op;
        b.ch       = ch;
        b.last     = last;
        b.typed    = typed;
        b.t_action = act;
        b.t_online = onl;
        tx_q.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [7:0] junk_char();
        return junk_set[$urandom_range(junk_set.len() - 1)];
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) fbuf.push_back(s[i]);
    endtask

    // Turns the frame buffer into beats; ticks may be slipped in between bytes.
    task automatic ship_frame(bit mix, bit typed, logic [2:0] act, bit onl);
        bit last;
        if (fbuf.size() == 0) fbuf.push_back(junk_char());
        for (int i = 0; i < fbuf.size(); i++) begin
            if (mix && $urandom_range(19) == 0)
                add_beat(acfp_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)), 0,
                         acfp_pkg::ACT_NONE, 0);
            last = (i == fbuf.size() - 1);
            add_beat(acfp_pkg::OP_BYTE, fbuf[i], last, last && typed, act, onl);
        end
        fbuf.delete();
    endtask

    // One decimal field: optional whitespace and sign, then digits biased to the limits.
    task automatic add_number();
        int          sel;
        int unsigned mag;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2))
                fbuf.push_back(($urandom_range(5) == 5) ? acfp_pkg::CH_SPACE :
                               8'(acfp_pkg::CH_TAB + $urandom_range(4)));
        sel = $urandom_range(9);
        if (sel < 2) fbuf.push_back(acfp_pkg::CH_MINUS);
        else if (sel == 2) fbuf.push_back(acfp_pkg::CH_PLUS);
        sel = $urandom_range(9);
        if (sel < 6) mag = $urandom_range(999);
        else if (sel < 8) mag = bound_mags[$urandom_range(7)];
        else mag = $urandom_range(1000, 9999999);
        if ($urandom_range(9) == 0) fbuf.push_back(acfp_pkg::CH_ZERO);
        add_text($sformatf("%0d", mag));
    endtask

    task automatic packet_body();
        fbuf.push_back(acfp_pkg::CH_LT);
        for (int k = 0; k < 5; k++) begin
            add_number();
            if (k < 4) fbuf.push_back(acfp_pkg::CH_COMMA);
        end
        if ($urandom_range(1) == 1) fbuf.push_back(CH_GT);
        repeat ($urandom_range(2)) fbuf.push_back(junk_char());
    endtask

    // Mostly well-formed packets; some are cut long, mangled or end early at a zero byte.
    task automatic packet_frame();
        logic [7:0] bad [5];
        if ($urandom_range(33) == 0)
            repeat ($urandom_range(100, 130)) fbuf.push_back(junk_char());
        else
            repeat ($urandom_range(3)) fbuf.push_back(junk_char());
        packet_body();
        if ($urandom_range(5) == 0) begin
            bad = '{acfp_pkg::CH_COMMA, acfp_pkg::CH_SPACE, acfp_pkg::CH_MINUS,
                    acfp_pkg::CH_LT, 8'($urandom_range(1, 255))};
            fbuf[$urandom_range(fbuf.size() - 1)] = bad[$urandom_range(4)];
        end
        if ($urandom_range(19) == 0) fbuf.insert($urandom_range(fbuf.size()), acfp_pkg::CH_NUL);
        ship_frame(1, 0, acfp_pkg::ACT_NONE, 0);
    endtask

    // Keywords, partial keywords and launch letters, sometimes next to a packet.
    task automatic command_frame();
        repeat ($urandom_range(3)) fbuf.push_back(junk_char());
        add_text(cmd_words[$urandom_range(11)]);
        if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(2)) fbuf.push_back(junk_char());
            add_text(cmd_words[$urandom_range(11)]);
        end
        if ($urandom_range(4) == 0) packet_body();
        if ($urandom_range(9) == 0) fbuf.insert($urandom_range(fbuf.size()), acfp_pkg::CH_NUL);
        repeat ($urandom_range(2)) fbuf.push_back(junk_char());
        ship_frame(1, 0, acfp_pkg::ACT_NONE, 0);
    endtask

    // Waits until every queued beat is taken and every predicted result has arrived.
    task automatic drain();
        while (beats_taken != beats_queued || due_reports.size() != 0) @(posedge i_clk);
    endtask

    // Writes the timeout while idle; result-less bytes may still be in the pipeline.
    task automatic set_timeout(logic [15:0] v);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_ticks = v;
        n_settings++;
    endtask

    task automatic random_phase(int budget);
        int stop_at;
        int pick;
        stop_at = beats_queued + budget;
        while (beats_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                packet_frame();
            end else if (pick < 60) begin
                command_frame();
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 12)) fbuf.push_back(8'($urandom_range(255)));
                ship_frame(1, 0, acfp_pkg::ACT_NONE, 0);
            end else begin
                repeat ($urandom_range(1, 8))
                    add_beat(acfp_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)), 0,
                             acfp_pkg::ACT_NONE, 0);
            end
            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(199) == 0) drain();
        end
    endtask

    // Test sequence.
    initial begin
        new_frame();
        pend_vals   = '0;
        kept_vals   = '0;
        idle_cnt    = 0;
        limit_ticks = acfp_pkg::TIMEOUT_RESET;
        n_settings  = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at the reset timeout.
        foreach (dir_table[i]) begin
            if (dir_table[i].tick) begin
                add_beat(acfp_pkg::OP_TICK, 8'($urandom), dir_table[i].tick_last,
                         dir_table[i].typed, dir_table[i].act, dir_table[i].onl);
            end else begin
                repeat (dir_table[i].pad) fbuf.push_back(FILLER);
                add_text(dir_table[i].head);
                if (dir_table[i].nul) fbuf.push_back(acfp_pkg::CH_NUL);
                add_text(dir_table[i].tail);
                ship_frame(0, dir_table[i].typed, dir_table[i].act, dir_table[i].onl);
            end
        end

        // Random traffic under a spread of timeouts; one phase runs without idling.
        set_timeout(16'd0);
        random_phase(125);
        set_timeout(16'd2);
        random_phase(125);
        set_timeout(16'd9);
        calm = 1'b1;
        random_phase(125);
        drain();
        calm = 1'b0;
        set_timeout(16'($urandom_range(10, 60)));
        random_phase(125);
        set_timeout(acfp_pkg::TIMEOUT_RESET);
        random_phase(125);
        set_timeout(16'hFFFF);
        random_phase(125);

        // Finish with the timeout just below its top: tick, packet, tick.
        set_timeout(16'hFFFE);
        add_beat(acfp_pkg::OP_TICK, 8'h00, 1'b0, 0, acfp_pkg::ACT_NONE, 0);
        packet_body();
        ship_frame(0, 0, acfp_pkg::ACT_NONE, 0);
        add_beat(acfp_pkg::OP_TICK, 8'h00, 1'b0, 0, acfp_pkg::ACT_NONE, 0);

        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d beats: %0d frames, %0d packets stored, %0d commands, %0d ticks.",
                 beats_taken, n_frames, n_packets, n_cmds, n_ticks);
        $display("Checked %0d results over %0d timeout settings; %0d mismatches.",
                 results_seen, n_settings, mismatches);
        if (mismatches == 0)
            $display("ascii_command_frame_parser_top verification clean");
        else
            $display("ascii_command_frame_parser_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/acfp_pkg.sv
rtl/acfp_kw_match.sv
rtl/acfp_num_parse.sv
rtl/ascii_command_frame_parser_top.sv
bench/tb_top.sv
